@@ hw/rtl/spq_pkg.sv @@
// Shared types and codes for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    // Operation carried in the input tuser field.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Control that the top level hands to every cell.
    typedef struct packed {
        logic push;      // insert the new entry this cycle
        logic pop;       // remove the front entry this cycle
        logic front;     // this cell is the front of the queue
        logic occupied;  // this cell holds a live entry
    } cell_ctl_t;

endpackage

@@ hw/rtl/spq_cell.sv @@
// One storage cell of the sorted priority queue chain.
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
#(
    parameter int PAYLOAD_WIDTH = 32,
    parameter int PRIO_WIDTH    = 16
)
(
    input  logic                         clk,
    input  cell_ctl_t                    ctl,
    input  logic [PAYLOAD_WIDTH-1:0]     new_payload,
    input  logic signed [PRIO_WIDTH-1:0] new_prio,
    input  logic                         left_ge,
    input  logic [PAYLOAD_WIDTH-1:0]     left_payload,
    input  logic signed [PRIO_WIDTH-1:0] left_prio,
    input  logic [PAYLOAD_WIDTH-1:0]     right_payload,
    input  logic signed [PRIO_WIDTH-1:0] right_prio,
    output logic                         ge,
    output logic [PAYLOAD_WIDTH-1:0]     payload,
    output logic signed [PRIO_WIDTH-1:0] prio
);

    logic [PAYLOAD_WIDTH-1:0]     payload_reg;
    logic [PAYLOAD_WIDTH-1:0]     payload_next;
    logic signed [PRIO_WIDTH-1:0] prio_reg;
    logic signed [PRIO_WIDTH-1:0] prio_next;

    // The new entry belongs at or before this cell. The front cell lets an
    // equal priority pass behind it; later cells stop at an equal one.
    assign ge = !ctl.occupied || (ctl.front ? (prio_reg > new_prio) : (prio_reg >= new_prio));

    always_comb
    begin
        payload_next = payload_reg;
        prio_next    = prio_reg;
        if (ctl.push)
        begin
            if (left_ge)
            begin
                payload_next = left_payload;
                prio_next    = left_prio;
            end
            else if (ge)
            begin
                payload_next = new_payload;
                prio_next    = new_prio;
            end
        end
        else if (ctl.pop)
        begin
            payload_next = right_payload;
            prio_next    = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
        prio_reg    <= prio_next;
    end

    assign payload = payload_reg;
    assign prio    = prio_reg;

endmodule

@@ hw/rtl/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: a row of shifting cells plus control.
`timescale 1ns / 1ps
// A result beat is registered and appears in the cycle after its input beat is accepted.
// One push or pop per cycle while the receiver keeps the output drained; the cell row shifts as a whole.
// The input is taken whenever the output register is empty or being drained.
// Reset clears the entry count and the output valid flag; cell contents are not
// cleared, since only entries below the count are ever read.

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH         = 16,
    parameter int PAYLOAD_WIDTH = 32,
    parameter int PRIO_WIDTH    = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // payload, prio (from bit 0 up), zero padded to whole bytes
    input  logic [((PAYLOAD_WIDTH+PRIO_WIDTH+7)/8)*8-1:0] s_tdata,
    // op
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // out_payload, out_prio, status, fill (from bit 0 up), zero padded to whole bytes
    output logic [((PAYLOAD_WIDTH+PRIO_WIDTH+2+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata
);

    localparam int CNT_WIDTH = $clog2(DEPTH + 1);
    localparam int OUT_WIDTH = ((PAYLOAD_WIDTH + PRIO_WIDTH + 2 + CNT_WIDTH + 7) / 8) * 8;

    // Input unpacking.
    logic [PAYLOAD_WIDTH-1:0]     in_payload;
    logic signed [PRIO_WIDTH-1:0] in_prio;

    assign in_payload = s_tdata[PAYLOAD_WIDTH-1:0];
    assign in_prio    = s_tdata[PAYLOAD_WIDTH +: PRIO_WIDTH];

    // Control state.
    logic [CNT_WIDTH-1:0] count_reg;
    logic [CNT_WIDTH-1:0] count_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;

    // Output register; the payload part needs no reset.
    logic [PAYLOAD_WIDTH-1:0]     out_payload_reg;
    logic [PAYLOAD_WIDTH-1:0]     out_payload_next;
    logic signed [PRIO_WIDTH-1:0] out_prio_reg;
    logic signed [PRIO_WIDTH-1:0] out_prio_next;
    logic [1:0]                   status_reg;
    logic [1:0]                   status_next;
    logic [CNT_WIDTH-1:0]         fill_reg;

    logic accept;
    logic is_pop;
    logic empty;
    logic full;
    logic do_push;
    logic do_pop;

    // The skid is the output register itself: a new beat enters as the old one leaves.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_pop   = (s_tuser == OP_POP);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_WIDTH'(DEPTH));
    assign do_push  = accept && !is_pop && !full;
    assign do_pop   = accept && is_pop && !empty;

    // Cell row. Each cell reports whether the new entry sorts at or before it;
    // the first cell that says so takes the new entry, the ones after it shift up.
    logic                         ge       [DEPTH];
    logic [PAYLOAD_WIDTH-1:0]     cell_pay [DEPTH];
    logic signed [PRIO_WIDTH-1:0] cell_pri [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            cell_ctl_t ctl;

            assign ctl.push     = do_push;
            assign ctl.pop      = do_pop;
            assign ctl.front    = (i == 0);
            assign ctl.occupied = (count_reg > CNT_WIDTH'(i));

            spq_cell #(
                .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
                .PRIO_WIDTH    (PRIO_WIDTH)
            ) u_cell (
                .clk           (clk),
                .ctl           (ctl),
                .new_payload   (in_payload),
                .new_prio      (in_prio),
                .left_ge       ((i == 0) ? 1'b0 : ge[(i == 0) ? 0 : i - 1]),
                .left_payload  (cell_pay[(i == 0) ? 0 : i - 1]),
                .left_prio     (cell_pri[(i == 0) ? 0 : i - 1]),
                .right_payload (cell_pay[(i == DEPTH - 1) ? i : i + 1]),
                .right_prio    (cell_pri[(i == DEPTH - 1) ? i : i + 1]),
                .ge            (ge[i]),
                .payload       (cell_pay[i]),
                .prio          (cell_pri[i])
            );
        end
    endgenerate

    // Result of the accepted beat and the new count.
    always_comb
    begin
        count_next       = count_reg;
        out_payload_next = '0;
        out_prio_next    = '0;
        status_next      = STATUS_OK;
        if (accept)
        begin
            if (is_pop)
            begin
                if (empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    out_payload_next = cell_pay[0];
                    out_prio_next    = cell_pri[0];
                    count_next       = count_reg - 1'b1;
                end
            end
            else
            begin
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    assign m_tvalid_next = accept || (m_tvalid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_payload_reg <= out_payload_next;
            out_prio_reg    <= out_prio_next;
            status_reg      <= status_next;
            fill_reg        <= count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_WIDTH'({fill_reg, status_reg, out_prio_reg, out_payload_reg});

`ifndef NO_ASSERTIONS
    // The entry count never runs past the number of cells.
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_WIDTH'(DEPTH))
        else $error("entry count exceeds depth");

    // A push into a queue with room grows the count by exactly one.
    a_push_grows : assert property (@(posedge clk) disable iff (!rst_n)
        do_push |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow the count");

    // A pop from a non-empty queue returns the old front entry.
    a_pop_front : assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |=> m_tvalid_reg && (out_prio_reg == $past(cell_pri[0]))
                   && (out_payload_reg == $past(cell_pay[0])))
        else $error("pop did not return the front entry");

    // The live entries stay in non-decreasing priority order.
    generate
        for (i = 0; i < DEPTH - 1; i++)
        begin : g_sorted
            a_sorted : assert property (@(posedge clk) disable iff (!rst_n)
                (count_reg > CNT_WIDTH'(i + 1)) |-> (cell_pri[i] <= cell_pri[i + 1]))
                else $error("queue entries out of order");
        end
    endgenerate
`endif

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the sorted priority queue, driven over its stream ports.
`timescale 1ns / 1ps

module tb
    import spq_pkg::*;
();

    localparam int DEPTH         = 16;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int PRIO_WIDTH    = 16;
    localparam int S_BITS        = ((PAYLOAD_WIDTH + PRIO_WIDTH + 7) / 8) * 8;
    localparam int M_BITS        =
        ((PAYLOAD_WIDTH + PRIO_WIDTH + 2 + $clog2(DEPTH + 1) + 7) / 8) * 8;
    localparam int RAND_PER_PHASE = 584;
    localparam int DIR_ROWS       = 25;

    // One result beat, split into its fields.
    typedef struct packed {
        logic [31:0] payload;
        logic [15:0] prio;
        logic [1:0]  status;
        logic [4:0]  fill;
    } queue_result_t;

    // What the monitor should compare an accepted input against: either a result
    // typed into the directed table, or whatever the queue model works out.
    typedef struct {
        bit            typed;
        queue_result_t res;
    } check_plan_t;

    // One row of the directed table.
    typedef struct {
        logic          op;
        logic [31:0]   payload;
        logic [15:0]   prio;
        bit            typed;
        queue_result_t res;
    } dir_row_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [S_BITS-1:0] s_tdata  = '0;
    logic              s_tuser  = OP_PUSH;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [M_BITS-1:0] m_tdata;

    // Idle rates in percent, changed between phases by the stimulus process.
    int send_idle = 11;
    int stall_pct = 84;
    int errors    = 0;

    queue_result_t pending_results[$];
    check_plan_t   check_plan[$];

    // Model of the queue contents, kept sorted with the smallest priority at index 0.
    logic [31:0]        held_payload[DEPTH];
    logic signed [15:0] held_prio[DEPTH];
    int                 held_count = 0;

    sorted_priority_queue i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // payload [31:0], prio [47:32]
        .s_tuser  (s_tuser),   // op
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // out_payload [31:0], out_prio [47:32], status [49:48], fill [54:50]
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // Directed table. Rows with a typed result check against that value; the rest
    // are checked against the model. The sequence walks through popping an empty
    // queue, both priority extremes, a tie with the front entry (lands behind it),
    // a tie further back (lands ahead of the equal entries), filling the queue to
    // the brim, pushing into the full queue, and draining a few entries.
    dir_row_t dir_tab[DIR_ROWS] = '{
        '{OP_POP,  32'h0000_0000, 16'h0000, 1'b1, '{32'h0, 16'h0000, STATUS_EMPTY, 5'd0}},
        '{OP_PUSH, 32'h0000_0000, 16'h8000, 1'b1, '{32'h0, 16'h0000, STATUS_OK, 5'd1}},
        '{OP_PUSH, 32'hFFFF_FFFF, 16'h7FFF, 1'b1, '{32'h0, 16'h0000, STATUS_OK, 5'd2}},
        '{OP_PUSH, 32'hA5A5_A5A5, 16'h0000, 1'b0, '0},
        '{OP_PUSH, 32'h0000_0001, 16'h8000, 1'b0, '0},
        '{OP_PUSH, 32'h0000_0002, 16'h0000, 1'b0, '0},
        '{OP_PUSH, 32'h0000_0003, 16'd100,  1'b0, '0},
        '{OP_POP,  32'h0000_0000, 16'h0000, 1'b1, '{32'h0, 16'h8000, STATUS_OK, 5'd5}},
        '{OP_POP,  32'h0000_0000, 16'h0000, 1'b0, '0},
        '{OP_PUSH, 32'h1111_0001, -16'sd5,  1'b0, '0},
        '{OP_PUSH, 32'h1111_0002, 16'd7,    1'b0, '0},
        '{OP_PUSH, 32'h1111_0003, 16'h0000, 1'b0, '0},
        '{OP_PUSH, 32'h1111_0004, 16'h7FFF, 1'b0, '0},
        '{OP_PUSH, 32'h1111_0005, 16'h8000, 1'b0, '0},
        '{OP_PUSH, 32'h1111_0006, 16'd12,   1'b0, '0},
        '{OP_PUSH, 32'h1111_0007, -16'sd1,  1'b0, '0},
        '{OP_PUSH, 32'h1111_0008, 16'd7,    1'b0, '0},
        '{OP_PUSH, 32'h1111_0009, 16'd300,  1'b0, '0},
        '{OP_PUSH, 32'h1111_000A, -16'sd300, 1'b0, '0},
        '{OP_PUSH, 32'h1111_000B, 16'h0000, 1'b0, '0},
        '{OP_PUSH, 32'h1111_000C, 16'd1,    1'b0, '0},
        '{OP_PUSH, 32'h5555_AAAA, 16'd42,   1'b1, '{32'h0, 16'h0000, STATUS_FULL, 5'd16}},
        '{OP_POP,  32'h0000_0000, 16'h0000, 1'b0, '0},
        '{OP_POP,  32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0},
        '{OP_POP,  32'h0000_0000, 16'h0000, 1'b0, '0}
    };

    // Applies one request to the queue model and returns the result beat it causes.
    function automatic queue_result_t serve_request(input logic op, input logic [31:0] pl,
                                                    input logic signed [15:0] pr);
        queue_result_t r;
        int            pos;
        r = '0;
        if (op == OP_PUSH)
        begin
            if (held_count >= DEPTH)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                // A tie with the front entry goes behind it; further back, a new
                // entry goes ahead of any entries of equal priority.
                if (held_count == 0 || held_prio[0] > pr)
                begin
                    pos = 0;
                end
                else
                begin
                    pos = 1;
                    while (pos < held_count && held_prio[pos] < pr)
                        pos++;
                end
                for (int i = held_count; i > pos; i--)
                begin
                    held_payload[i] = held_payload[i-1];
                    held_prio[i]    = held_prio[i-1];
                end
                held_payload[pos] = pl;
                held_prio[pos]    = pr;
                held_count++;
            end
        end
        else
        begin
            if (held_count == 0)
            begin
                r.status = STATUS_EMPTY;
            end
            else
            begin
                r.payload = held_payload[0];
                r.prio    = held_prio[0];
                for (int i = 1; i < held_count; i++)
                begin
                    held_payload[i-1] = held_payload[i];
                    held_prio[i-1]    = held_prio[i];
                end
                held_count--;
            end
        end
        r.status = (r.status == STATUS_OK) ? STATUS_OK : r.status;
        r.fill   = held_count[4:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s, got %0h, want %0h", $time, what, got, want);
        errors++;
    endtask

    // Priorities are drawn in part from a narrow band so that ties happen often, with the
    // extremes and fully random values mixed in.
    function automatic logic [15:0] pick_prio();
        logic [15:0] p;
        int          sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            p = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        else if (sel <= 3)
            p = 16'($urandom_range(0, 8)) - 16'd4;
        else
            p = 16'($urandom);
        return p;
    endfunction

    // Offers one beat on the input side and returns at the edge where it is taken.
    // The sender may idle first; valid is only ever written once per edge.
    task automatic offer_beat(input logic op, input logic [31:0] pl, input logic [15:0] pr,
                              input bit typed, input queue_result_t res);
        check_plan_t plan;
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        plan.typed = typed;
        plan.res   = res;
        check_plan.push_back(plan);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pr, pl};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // The receiver stalls at the rate of the current phase.
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    // Monitor: every edge it first checks a result beat taken at this edge, then
    // runs an input beat taken at this edge through the model. Values are read
    // before the edge takes effect, since all drivers use nonblocking writes.
    always @(posedge clk)
    begin : monitor
        queue_result_t got;
        queue_result_t want;
        queue_result_t modeled;
        check_plan_t   plan;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.payload = m_tdata[31:0];
                got.prio    = m_tdata[47:32];
                got.status  = m_tdata[49:48];
                got.fill    = m_tdata[54:50];
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result beat with nothing pending", 64'(got), 64'h0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.payload !== want.payload)
                        report_mismatch("out_payload", 64'(got.payload), 64'(want.payload));
                    if (got.prio !== want.prio)
                        report_mismatch("out_prio", 64'(got.prio), 64'(want.prio));
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.fill !== want.fill)
                        report_mismatch("fill", 64'(got.fill), 64'(want.fill));
                end
            end
            if (s_tvalid && s_tready)
            begin
                plan    = check_plan.pop_front();
                modeled = serve_request(s_tuser, s_tdata[31:0], s_tdata[47:32]);
                pending_results.push_back(plan.typed ? plan.res : modeled);
            end
        end
    end

    initial
    begin : stimulus
        int            push_pct;
        logic          op;
        queue_result_t none;
        none     = '0;
        push_pct = 50;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            offer_beat(dir_tab[i].op, dir_tab[i].payload, dir_tab[i].prio,
                       dir_tab[i].typed, dir_tab[i].res);

        // Three phases: slow receiver, then slow sender, then both at full rate.
        // Within each phase the push share is drawn anew every 48 beats so the
        // queue keeps swinging between empty and full.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 11;
                    stall_pct = 84;
                end
                1:
                begin
                    send_idle = 84;
                    stall_pct = 11;
                end
                default:
                begin
                    send_idle = 0;
                    stall_pct = 0;
                end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                if (n % 48 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       push_pct = 15;
                        1:       push_pct = 50;
                        default: push_pct = 85;
                    endcase
                end
                op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                offer_beat(op, $urandom, pick_prio(), 1'b0, none);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0 || check_plan.size() != 0)
            @(posedge clk);
        // Keep the clock running past the drain so that a stray extra result beat would be caught.
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Guard against a hang; far above the slowest correct run.
    initial
    begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
